### hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, codes and structs of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

   // field widths as seen on the ports and carried along the cell chain
   localparam int SLOT_W      = 4;
   localparam int PRIO_W      = 8;
   localparam int CORE_W      = 3;
   localparam int CSR_INDEX_W = 1;

   localparam int DEF_TASK_SLOTS    = 16;
   localparam int DEF_CORE_COUNT    = 8;
   localparam int DEF_PRIORITY_BITS = 8;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_BLOCK    = 2'd2,
      OP_WAKEUP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      TS_READY   = 2'd0,
      TS_RUNNING = 2'd1,
      TS_BLOCKED = 2'd2,
      TS_WAITING = 2'd3
   } task_state_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THIS_CORE     = 1'b0,
      CSR_IDLE_PRIORITY = 1'b1
   } csr_index_type;

   // running candidate or lookup hit, handed from cell to cell
   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [PRIO_W-1:0]   prio;
      task_state_type      state;
      logic [CORE_W-1:0]   core;
   } scan_token_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic                scan;        // pick best ready, else look up query_slot
      logic [SLOT_W-1:0]   query_slot;
      logic                state_wr;
      logic [SLOT_W-1:0]   wr_slot;
      task_state_type      wr_state;
      logic                commit;
      logic [SLOT_W-1:0]   best_slot;
      logic                cur_valid;
      logic [SLOT_W-1:0]   cur_slot;
      logic [SLOT_W-1:0]   new_slot;
      logic [PRIO_W-1:0]   new_prio;
      logic [CORE_W-1:0]   new_core;
   } cell_cmd_type;

endpackage

### hw/rtl/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell
// One queue position of the task table: holds one task and passes the scan
// token on to the next position every cycle.
// ----------------------------------------------------------------------------
module pts_cell #(
   parameter int STORE_PRIO_W = 8,
   parameter int STORE_CORE_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          preload,
   input  pts_pkg::cell_cmd_type         cmd,
   input  logic                          append,
   input  logic [pts_pkg::CORE_W-1:0]    this_core,
   input  logic [pts_pkg::PRIO_W-1:0]    idle_priority,
   input  pts_pkg::scan_token_type       tok_in,
   output pts_pkg::scan_token_type       tok_out
);

   localparam int PW = pts_pkg::PRIO_W;
   localparam int CW = pts_pkg::CORE_W;

   logic                        used_ff, used_in;
   logic [pts_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   pts_pkg::task_state_type     state_ff, state_in;
   logic [STORE_PRIO_W-1:0]     prio_ff, prio_in;
   logic [STORE_CORE_W-1:0]     core_ff, core_in;
   pts_pkg::scan_token_type     pass_ff, pass_in;

   logic                        is_idle;
   logic [PW-1:0]               my_prio;
   logic [CW-1:0]               my_core;
   pts_pkg::scan_token_type     mine;

   // the idle task takes its priority and home core from the live registers
   assign is_idle = (slot_ff == '0);
   assign my_prio = is_idle ? idle_priority : PW'(prio_ff);
   assign my_core = is_idle ? this_core : CW'(core_ff);

   always_comb begin
      mine.found = 1'b1;
      mine.slot  = slot_ff;
      mine.prio  = my_prio;
      mine.state = state_ff;
      mine.core  = my_core;

      pass_in = tok_in;
      if (used_ff) begin
         if (cmd.scan) begin
            if (state_ff == pts_pkg::TS_READY && (!tok_in.found || my_prio > tok_in.prio)) begin
               pass_in = mine;
            end
         end else if (slot_ff == cmd.query_slot) begin
            pass_in = mine;
         end
      end
   end

   always_comb begin
      used_in  = used_ff;
      slot_in  = slot_ff;
      state_in = state_ff;
      prio_in  = prio_ff;
      core_in  = core_ff;

      if (append) begin
         used_in  = 1'b1;
         slot_in  = cmd.new_slot;
         prio_in  = cmd.new_prio[STORE_PRIO_W-1:0];
         core_in  = cmd.new_core[STORE_CORE_W-1:0];
         state_in = pts_pkg::TS_READY;
      end

      if (used_ff && cmd.state_wr && slot_ff == cmd.wr_slot) begin
         state_in = cmd.wr_state;
      end

      // previous task back to ready, chosen one running
      if (used_ff && cmd.commit) begin
         if (slot_ff == cmd.best_slot) begin
            state_in = pts_pkg::TS_RUNNING;
         end else if (cmd.cur_valid && slot_ff == cmd.cur_slot &&
                      state_ff == pts_pkg::TS_RUNNING) begin
            state_in = pts_pkg::TS_READY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= preload;
         slot_ff  <= '0;
         state_ff <= pts_pkg::TS_READY;
      end else begin
         used_ff  <= used_in;
         slot_ff  <= slot_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      core_ff <= core_in;
      pass_ff <= pass_in;
   end

   assign tok_out = pass_ff;

endmodule

### hw/rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority preemptive task table for one core, built as a chain of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the fields on the
// req_ ports are sampled at that edge. Each request yields exactly one result,
// shown on the rsp_ ports for a single cycle while rsp_valid is high. The
// receiver cannot stall, so results are never held back.
// Enqueue, schedule, block and wakeup walk a token down the chain of
// TASK_SLOTS cells, one cell a cycle; a block first writes the new state of
// the running task before its walk. Requests refused or ignored on their
// fields alone (slot out of range, table full, block with nothing running)
// answer in the next cycle. busy stays high while a walk is under way; a new
// request can be taken in the cycle its result is shown.
// The csr_ port writes this_core (index 0) and idle_priority (index 1); the
// user must do so only while idle; the block does not enforce it. Reset leaves
// only the idle task in slot 0, all tasks ready, none running, registers at 0.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
   parameter int TASK_SLOTS    = pts_pkg::DEF_TASK_SLOTS,
   parameter int CORE_COUNT    = pts_pkg::DEF_CORE_COUNT,
   parameter int PRIORITY_BITS = pts_pkg::DEF_PRIORITY_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic [pts_pkg::SLOT_W-1:0]       req_task_slot,
   input  logic [pts_pkg::PRIO_W-1:0]       req_task_priority,
   input  logic [pts_pkg::CORE_W-1:0]       req_home_core,
   input  logic [1:0]                       req_block_state,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [pts_pkg::SLOT_W-1:0]       rsp_running_slot,
   output logic                             rsp_switched,
   output logic                             rsp_ipi_request,
   output logic [pts_pkg::CORE_W-1:0]       rsp_ipi_core,
   input  logic                             csr_write_en,
   input  logic [pts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pts_pkg::PRIO_W-1:0]       csr_wdata
);

   localparam int SW = pts_pkg::SLOT_W;
   localparam int PW = pts_pkg::PRIO_W;
   localparam int CW = pts_pkg::CORE_W;
   localparam int LEN_W = $clog2(TASK_SLOTS + 1);
   localparam int CNT_W = $clog2(TASK_SLOTS);
   localparam int CELL_PRIO_W = (PRIORITY_BITS < PW) ? PRIORITY_BITS : PW;
   localparam int CELL_CORE_W = (CORE_COUNT <= 2) ? 1 : ((CORE_COUNT <= 4) ? 2 : CW);
   localparam logic [CW-1:0] CORE_SAT = (CORE_COUNT > 8) ? {CW{1'b1}} : CW'(CORE_COUNT - 1);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_PREWRITE = 4'b0010,
      S_WAIT     = 4'b0100,
      S_FINISH   = 4'b1000
   } fsm_state_type;

   fsm_state_type               state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   pts_pkg::op_type             op_ff, op_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [PW-1:0]               prio_ff, prio_in;
   logic [CW-1:0]               core_ff, core_in;
   pts_pkg::task_state_type     bst_ff, bst_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [SW-1:0]               cur_slot_ff, cur_slot_in;
   logic                        cur_valid_ff, cur_valid_in;
   logic [CW-1:0]               this_core_ff;
   logic [PW-1:0]               idle_prio_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   pts_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [SW-1:0]               rsp_slot_ff, rsp_slot_in;
   logic                        rsp_switched_ff, rsp_switched_in;
   logic                        rsp_ipi_ff, rsp_ipi_in;
   logic [CW-1:0]               rsp_ipi_core_ff, rsp_ipi_core_in;

   pts_pkg::cell_cmd_type       cmd;
   logic [TASK_SLOTS-1:0]       append_sel;
   logic                        do_append;
   pts_pkg::scan_token_type     tok_into [TASK_SLOTS];
   pts_pkg::scan_token_type     tok_from [TASK_SLOTS];
   pts_pkg::scan_token_type     tok_last;
   logic [SW-1:0]               best;
   logic [CW-1:0]               home_sat;

   assign tok_last = tok_from[TASK_SLOTS-1];
   assign best     = tok_last.found ? tok_last.slot : '0;
   assign home_sat = (32'(req_home_core) > CORE_COUNT - 1) ? CORE_SAT : req_home_core;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      op_in           = op_ff;
      slot_in         = slot_ff;
      prio_in         = prio_ff;
      core_in         = core_ff;
      bst_in          = bst_ff;
      len_in          = len_ff;
      cur_slot_in     = cur_slot_ff;
      cur_valid_in    = cur_valid_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_ipi_in      = rsp_ipi_ff;
      rsp_ipi_core_in = rsp_ipi_core_ff;
      do_append       = 1'b0;

      cmd            = '0;
      cmd.scan       = (op_ff == pts_pkg::OP_SCHEDULE) || (op_ff == pts_pkg::OP_BLOCK);
      cmd.query_slot = slot_ff;
      cmd.wr_slot    = slot_ff;
      cmd.wr_state   = pts_pkg::TS_READY;
      cmd.best_slot  = best;
      cmd.cur_valid  = cur_valid_ff;
      cmd.cur_slot   = cur_slot_ff;
      cmd.new_slot   = slot_ff;
      cmd.new_prio   = prio_ff;
      cmd.new_core   = core_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = pts_pkg::op_type'(req_op);
               slot_in = req_task_slot;
               prio_in = req_task_priority;
               core_in = home_sat;
               bst_in  = pts_pkg::task_state_type'(req_block_state);
               cnt_in  = '0;
               // answers settled by the fields alone
               rsp_slot_in     = cur_slot_ff;
               rsp_switched_in = 1'b0;
               rsp_ipi_in      = 1'b0;
               rsp_ipi_core_in = '0;
               unique case (pts_pkg::op_type'(req_op))
                  pts_pkg::OP_ENQUEUE: begin
                     if (32'(req_task_slot) >= TASK_SLOTS || len_ff >= LEN_W'(TASK_SLOTS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pts_pkg::ST_REFUSED;
                     end else begin
                        state_in = S_WAIT;
                     end
                  end
                  pts_pkg::OP_SCHEDULE: begin
                     state_in = S_WAIT;
                  end
                  pts_pkg::OP_BLOCK: begin
                     if (!cur_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pts_pkg::ST_IGNORED;
                     end else begin
                        state_in = S_PREWRITE;
                     end
                  end
                  pts_pkg::OP_WAKEUP: begin
                     if (32'(req_task_slot) >= TASK_SLOTS) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pts_pkg::ST_IGNORED;
                     end else begin
                        state_in = S_WAIT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_PREWRITE: begin
            cmd.state_wr = 1'b1;
            cmd.wr_slot  = cur_slot_ff;
            cmd.wr_state = bst_ff;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            // wait while the token walks down the chain to its last cell
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TASK_SLOTS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in        = S_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = pts_pkg::ST_DONE;
            rsp_switched_in = 1'b0;
            rsp_ipi_in      = 1'b0;
            rsp_ipi_core_in = '0;
            case (op_ff)
               pts_pkg::OP_ENQUEUE: begin
                  if (tok_last.found) begin
                     rsp_status_in = pts_pkg::ST_REFUSED;
                  end else begin
                     do_append = 1'b1;
                     len_in    = len_ff + 1'b1;
                  end
               end
               pts_pkg::OP_WAKEUP: begin
                  if (!tok_last.found || tok_last.state != pts_pkg::TS_BLOCKED) begin
                     rsp_status_in = pts_pkg::ST_IGNORED;
                  end else begin
                     cmd.state_wr = 1'b1;
                     cmd.wr_slot  = slot_ff;
                     cmd.wr_state = pts_pkg::TS_READY;
                     if (tok_last.core != this_core_ff) begin
                        rsp_ipi_in      = 1'b1;
                        rsp_ipi_core_in = tok_last.core;
                     end
                  end
               end
               default: begin
                  cmd.commit      = 1'b1;
                  rsp_switched_in = !cur_valid_ff || (cur_slot_ff != best);
                  cur_slot_in     = best;
                  cur_valid_in    = 1'b1;
               end
            endcase
            rsp_slot_in = cur_slot_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      for (int i = 0; i < TASK_SLOTS; i++) begin
         append_sel[i] = do_append && (len_ff == LEN_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         len_ff       <= LEN_W'(1);
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      slot_ff         <= slot_in;
      prio_ff         <= prio_in;
      core_ff         <= core_in;
      bst_ff          <= bst_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_ipi_ff      <= rsp_ipi_in;
      rsp_ipi_core_ff <= rsp_ipi_core_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         this_core_ff <= '0;
         idle_prio_ff <= '0;
      end else if (csr_write_en) begin
         unique case (pts_pkg::csr_index_type'(csr_index))
            pts_pkg::CSR_THIS_CORE:     this_core_ff <= csr_wdata[CW-1:0];
            pts_pkg::CSR_IDLE_PRIORITY: idle_prio_ff <= csr_wdata;
            default:                    idle_prio_ff <= idle_prio_ff;
         endcase
      end
   end

   for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign tok_into[g] = '0;
      end else begin : g_link
         assign tok_into[g] = tok_from[g-1];
      end

      pts_cell #(
         .STORE_PRIO_W (CELL_PRIO_W),
         .STORE_CORE_W (CELL_CORE_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .preload       (1'(g == 0)),
         .cmd           (cmd),
         .append        (append_sel[g]),
         .this_core     (this_core_ff),
         .idle_priority (idle_prio_ff),
         .tok_in        (tok_into[g]),
         .tok_out       (tok_from[g])
      );
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_running_slot = rsp_slot_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_ipi_request  = rsp_ipi_ff;
   assign rsp_ipi_core     = rsp_ipi_core_ff;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority task scheduler. A predictor in the
// bench keeps its own copy of the task table and works out the response to
// every request as it is accepted. Directed tests cover refusals, ignored
// requests, preemption and the idle task registers. Random traffic then runs
// under several register settings, with random request gaps in all but one.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_SLOTS    = pts_pkg::DEF_TASK_SLOTS;
   localparam int CORE_COUNT    = pts_pkg::DEF_CORE_COUNT;
   localparam int PRIORITY_BITS = pts_pkg::DEF_PRIORITY_BITS;
   localparam int SLOT_W        = pts_pkg::SLOT_W;
   localparam int PRIO_W        = pts_pkg::PRIO_W;
   localparam int CORE_W        = pts_pkg::CORE_W;
   localparam int CSR_INDEX_W   = pts_pkg::CSR_INDEX_W;

   typedef struct packed {
      pts_pkg::status_type status;
      logic [SLOT_W-1:0]   running;
      logic                switched;
      logic                ipi;
      logic [CORE_W-1:0]   ipi_core;
   } outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_op = '0;
   logic [SLOT_W-1:0]    req_task_slot = '0;
   logic [PRIO_W-1:0]    req_task_priority = '0;
   logic [CORE_W-1:0]    req_home_core = '0;
   logic [1:0]           req_block_state = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [SLOT_W-1:0]    rsp_running_slot;
   logic                 rsp_switched;
   logic                 rsp_ipi_request;
   logic [CORE_W-1:0]    rsp_ipi_core;
   logic                 csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [PRIO_W-1:0]    csr_wdata = '0;

   // predicted table
   logic                     slot_valid [TASK_SLOTS];
   logic [PRIO_W-1:0]        slot_prio  [TASK_SLOTS];
   pts_pkg::task_state_type  slot_state [TASK_SLOTS];
   logic [CORE_W-1:0]        slot_core  [TASK_SLOTS];
   logic [SLOT_W-1:0]        scan_order [TASK_SLOTS];
   int                       order_len;
   logic [SLOT_W-1:0]        cur_slot;
   logic                     cur_valid;
   logic [CORE_W-1:0]        cfg_this_core;
   logic [PRIO_W-1:0]        cfg_idle_prio;

   outcome_type          pending_outcomes [$];
   int                   mismatch_count = 0;
   logic                 gaps_on = 1'b1;

   priority_task_scheduler #(
      .TASK_SLOTS    (TASK_SLOTS),
      .CORE_COUNT    (CORE_COUNT),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_task_slot     (req_task_slot),
      .req_task_priority (req_task_priority),
      .req_home_core     (req_home_core),
      .req_block_state   (req_block_state),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_running_slot  (rsp_running_slot),
      .rsp_switched      (rsp_switched),
      .rsp_ipi_request   (rsp_ipi_request),
      .rsp_ipi_core      (rsp_ipi_core),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [PRIO_W-1:0] prio_of(logic [SLOT_W-1:0] s);
      return (s == 0) ? cfg_idle_prio : slot_prio[s];
   endfunction

   // scan in insertion order for the first ready task of highest priority
   function automatic logic next_running_task();
      logic [SLOT_W-1:0] best;
      logic [SLOT_W-1:0] s;
      logic [PRIO_W-1:0] best_prio;
      logic              found;
      logic              changed;
      best = '0;
      best_prio = '0;
      found = 1'b0;
      for (int i = 0; i < order_len && i < TASK_SLOTS; i++) begin
         s = scan_order[i];
         if (slot_state[s] == pts_pkg::TS_READY && (!found || prio_of(s) > best_prio)) begin
            best = s;
            best_prio = prio_of(s);
            found = 1'b1;
         end
      end
      if (!found)
         best = '0;
      if (cur_valid && slot_state[cur_slot] == pts_pkg::TS_RUNNING)
         slot_state[cur_slot] = pts_pkg::TS_READY;
      slot_state[best] = pts_pkg::TS_RUNNING;
      changed = !cur_valid || cur_slot != best;
      cur_slot = best;
      cur_valid = 1'b1;
      return changed;
   endfunction

   function automatic outcome_type scheduler_outcome(pts_pkg::op_type op,
                                                     logic [SLOT_W-1:0] slot,
                                                     logic [PRIO_W-1:0] prio,
                                                     logic [CORE_W-1:0] home,
                                                     pts_pkg::task_state_type bst);
      outcome_type       r;
      logic [CORE_W-1:0] home_sat;
      logic [PRIO_W-1:0] prio_m;
      logic [CORE_W-1:0] target;
      r = '{pts_pkg::ST_DONE, '0, 1'b0, 1'b0, '0};
      home_sat = (int'(home) > CORE_COUNT - 1) ? CORE_W'(CORE_COUNT - 1) : home;
      prio_m = prio & PRIO_W'((1 << PRIORITY_BITS) - 1);
      case (op)
         pts_pkg::OP_ENQUEUE: begin
            if (int'(slot) >= TASK_SLOTS || slot_valid[slot] || order_len >= TASK_SLOTS) begin
               r.status = pts_pkg::ST_REFUSED;
            end else begin
               slot_valid[slot] = 1'b1;
               slot_prio[slot] = prio_m;
               slot_core[slot] = home_sat;
               slot_state[slot] = pts_pkg::TS_READY;
               scan_order[order_len] = slot;
               order_len++;
            end
         end
         pts_pkg::OP_SCHEDULE: begin
            r.switched = next_running_task();
         end
         pts_pkg::OP_BLOCK: begin
            if (!cur_valid) begin
               r.status = pts_pkg::ST_IGNORED;
            end else begin
               slot_state[cur_slot] = bst;
               r.switched = next_running_task();
            end
         end
         default: begin
            if (int'(slot) >= TASK_SLOTS || !slot_valid[slot]
                || slot_state[slot] != pts_pkg::TS_BLOCKED) begin
               r.status = pts_pkg::ST_IGNORED;
            end else begin
               slot_state[slot] = pts_pkg::TS_READY;
               target = (slot == 0) ? cfg_this_core : slot_core[slot];
               if (target != cfg_this_core) begin
                  r.ipi = 1'b1;
                  r.ipi_core = target;
               end
            end
         end
      endcase
      r.running = cur_slot;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("%0t: %s differs, got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response", 8'(rsp_running_slot), 8'h0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 8'(rsp_status), 8'(want.status));
            if (rsp_running_slot !== want.running)
               report_mismatch("running_slot", 8'(rsp_running_slot), 8'(want.running));
            if (rsp_switched !== want.switched)
               report_mismatch("switched", 8'(rsp_switched), 8'(want.switched));
            if (rsp_ipi_request !== want.ipi)
               report_mismatch("ipi_request", 8'(rsp_ipi_request), 8'(want.ipi));
            if (rsp_ipi_core !== want.ipi_core)
               report_mismatch("ipi_core", 8'(rsp_ipi_core), 8'(want.ipi_core));
         end
      end
   end

   task automatic send_request(pts_pkg::op_type op, logic [SLOT_W-1:0] slot,
                               logic [PRIO_W-1:0] prio, logic [CORE_W-1:0] home,
                               pts_pkg::task_state_type bst);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(99) < 9) begin
         gap = $urandom_range(24, 1);
         repeat (gap) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_op <= op;
      req_task_slot <= slot;
      req_task_priority <= prio;
      req_home_core <= home;
      req_block_state <= bst;
      do @(posedge clock); while (busy !== 1'b0);
      pending_outcomes.push_back(scheduler_outcome(op, slot, prio, home, bst));
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic write_csr(pts_pkg::csr_index_type idx, logic [PRIO_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == pts_pkg::CSR_THIS_CORE)
         cfg_this_core = data[CORE_W-1:0];
      else
         cfg_idle_prio = data;
   endtask

   task automatic test_ignored_requests();
      // nothing runs yet, so block has no effect
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_BLOCKED);
      send_request(pts_pkg::OP_WAKEUP, 4'd5, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_WAKEUP, 4'd0, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_ENQUEUE, 4'd0, 8'd9, 3'd1, pts_pkg::TS_READY);
   endtask

   task automatic test_enqueue_limits();
      send_request(pts_pkg::OP_ENQUEUE, 4'd15, 8'd255, 3'd7, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_ENQUEUE, 4'd1, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_ENQUEUE, 4'd2, 8'd255, 3'd3, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_ENQUEUE, 4'd15, 8'd17, 3'd2, pts_pkg::TS_READY);
   endtask

   task automatic test_preemption_and_block();
      send_request(pts_pkg::OP_SCHEDULE, 4'd0, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_SCHEDULE, 4'd0, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_BLOCKED);
      send_request(pts_pkg::OP_WAKEUP, 4'd2, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_WAITING);
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_READY);
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_RUNNING);
      send_request(pts_pkg::OP_WAKEUP, 4'd15, 8'd0, 3'd0, pts_pkg::TS_READY);
   endtask

   task automatic test_idle_registers();
      logic [SLOT_W-1:0] victim;
      wait_until_drained();
      // upper data bits set, only the low three reach this_core
      write_csr(pts_pkg::CSR_THIS_CORE, 8'hFF);
      write_csr(pts_pkg::CSR_IDLE_PRIORITY, 8'd255);
      send_request(pts_pkg::OP_SCHEDULE, 4'd0, 8'd0, 3'd0, pts_pkg::TS_READY);
      victim = cur_slot;
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_BLOCKED);
      send_request(pts_pkg::OP_WAKEUP, victim, 8'd0, 3'd0, pts_pkg::TS_READY);
      wait_until_drained();
      write_csr(pts_pkg::CSR_THIS_CORE, 8'h03);
      victim = cur_slot;
      send_request(pts_pkg::OP_BLOCK, 4'd0, 8'd0, 3'd0, pts_pkg::TS_BLOCKED);
      send_request(pts_pkg::OP_WAKEUP, victim, 8'd0, 3'd0, pts_pkg::TS_READY);
   endtask

   task automatic send_random_request();
      int                      pick;
      int                      w;
      pts_pkg::op_type         op;
      logic [SLOT_W-1:0]       slot;
      pts_pkg::task_state_type bst;
      logic [SLOT_W-1:0]       blocked [$];
      pick = $urandom_range(99);
      w = $urandom_range(99);
      slot = SLOT_W'($urandom_range(TASK_SLOTS - 1));
      bst = (w < 50) ? pts_pkg::TS_BLOCKED :
            (w < 75) ? pts_pkg::TS_READY :
            (w < 96) ? pts_pkg::TS_RUNNING : pts_pkg::TS_WAITING;
      if (pick < 15) begin
         op = pts_pkg::OP_ENQUEUE;
      end else if (pick < 45) begin
         op = pts_pkg::OP_SCHEDULE;
      end else if (pick < 75) begin
         op = pts_pkg::OP_BLOCK;
      end else begin
         op = pts_pkg::OP_WAKEUP;
         // mostly wake a task that is really blocked
         for (int i = 0; i < TASK_SLOTS; i++)
            if (slot_valid[i] && slot_state[i] == pts_pkg::TS_BLOCKED)
               blocked.push_back(SLOT_W'(i));
         if (blocked.size() > 0 && $urandom_range(99) < 75)
            slot = blocked[$urandom_range(blocked.size() - 1)];
      end
      send_request(op, slot, PRIO_W'($urandom), CORE_W'($urandom), bst);
   endtask

   task automatic test_random_traffic();
      logic [CORE_W-1:0] phase_core [5];
      logic [PRIO_W-1:0] phase_prio [5];
      phase_core = '{3'd3, 3'd7, 3'd0, CORE_W'($urandom), CORE_W'($urandom)};
      phase_prio = '{8'd128, 8'd255, 8'd0, PRIO_W'($urandom), PRIO_W'($urandom)};
      for (int p = 0; p < 5; p++) begin
         wait_until_drained();
         write_csr(pts_pkg::CSR_THIS_CORE,
                   {PRIO_W'($urandom) & 8'hF8} | PRIO_W'(phase_core[p]));
         write_csr(pts_pkg::CSR_IDLE_PRIORITY, phase_prio[p]);
         // one phase runs back to back with no gaps
         gaps_on = (p != 1);
         repeat (90) send_random_request();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_prio[i] = '0;
         slot_state[i] = pts_pkg::TS_READY;
         slot_core[i] = '0;
         scan_order[i] = '0;
      end
      slot_valid[0] = 1'b1;
      order_len = 1;
      cur_slot = '0;
      cur_valid = 1'b0;
      cfg_this_core = '0;
      cfg_idle_prio = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_requests();
      test_enqueue_limits();
      test_preemption_and_block();
      test_idle_registers();
      test_random_traffic();

      wait_until_drained();
      repeat (TASK_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
